FILE: hw/rtl/tpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared constants, types and helper functions of the partial trace block.
// ----------------------------------------------------------------------------
package tpt_pkg;

  // Accumulator store depth and derived address width.
  localparam int RESULT_DEPTH = 1024;
  localparam int ADDR_W       = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;

  // Field widths.
  localparam int ELEM_W = 32;
  localparam int SUM_W  = 48;
  localparam int SIZE_W = 11;
  localparam int CNT_W  = 10;
  localparam int MAX_SIZE = 1024;

  // Index arithmetic widths: middle + middle_size * inner, then
  // outer + outer_size * that.
  localparam int T1_W   = SIZE_W + CNT_W;
  localparam int IDX_W  = SIZE_W + T1_W;
  // Entry total: outer_size * middle_size * inner_size.
  localparam int PROD_W = 2 * SIZE_W;
  localparam int TOT_W  = 3 * SIZE_W;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TRACE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_TRACE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER        = 3'd4;

  // Request commands.
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0] outer;
    logic [SIZE_W-1:0] first_trace;
    logic [SIZE_W-1:0] middle;
    logic [SIZE_W-1:0] second_trace;
    logic [SIZE_W-1:0] inner;
  } cfg_t;

  // Accumulator store access for one cycle.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_zero;
  } acc_ctl_t;

  // Zero reads as one, anything above the largest size reads as that size.
  function automatic logic [SIZE_W-1:0] size_clamp(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_SIZE)) begin
      r = SIZE_W'(MAX_SIZE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Add an element to a sum, pinned at the Q32.16 limits.
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]  acc,
    input logic signed [ELEM_W-1:0] e
  );
    logic signed [SUM_W:0]   s;
    logic signed [SUM_W-1:0] r;
    s = (SUM_W+1)'(acc) + (SUM_W+1)'(e);
    if (s[SUM_W] != s[SUM_W-1]) begin
      r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = s[SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/tpt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_if
// Request and response channels of the partial trace block.
// ----------------------------------------------------------------------------
interface tpt_req_if import tpt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [ELEM_W-1:0] element;

  modport source (output valid, command, element, input ready);
  modport sink   (input valid, command, element, output ready);
endinterface

interface tpt_rsp_if import tpt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum_value;
  logic                    last_entry;

  modport source (output valid, sum_value, last_entry, input ready);
  modport sink   (input valid, sum_value, last_entry, output ready);
endinterface

FILE: hw/rtl/tensor_partial_trace_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_partial_trace_accumulator
// Streams a five-way grouped tensor and accumulates its partial trace.
// ----------------------------------------------------------------------------
// Usage: after reset the block zeroes every entry of its accumulator memory
// and takes no request until that is done; configuration writes are taken
// at any time. A push request (command 0) steps through accept, index
// multiply, memory read, saturating add and write-back. A drain request
// (command 1) reads its entry, waits for the read data and then for the
// response slot to empty; the response register lets a push proceed while
// a result waits. Throughput is set by the read-modify-write of the single
// accumulator memory and the two-stage index multiplier; one request is in
// flight at a time.
// ----------------------------------------------------------------------------
module tensor_partial_trace_accumulator import tpt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [SIZE_W-1:0]    wr_data,
  tpt_req_if.sink              req,
  tpt_rsp_if.source            rsp
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_IDX   = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_DWAIT = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  cfg_t cfg;

  logic [2:0] state;
  logic [2:0] state_next;

  logic                     req_accept;
  logic                     clr_busy;
  logic signed [ELEM_W-1:0] elem;
  logic [ADDR_W-1:0]        ptr;
  logic [ADDR_W-1:0]        ptr_next;

  logic [PROD_W-1:0] prod01;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  ptr_inc;
  logic              is_last;

  logic [ADDR_W-1:0]       idx;
  logic                    hit;
  logic                    advance;
  acc_ctl_t                acc_ctl;
  logic signed [SUM_W-1:0] rd_data;

  logic                    rsp_valid;
  logic                    rsp_load;
  logic                    slot_free;
  logic signed [SUM_W-1:0] sum_q;
  logic                    last_q;

  // Configuration registers hold the clamped size; indexes past the list drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.outer        <= SIZE_W'(1);
      cfg.first_trace  <= SIZE_W'(1);
      cfg.middle       <= SIZE_W'(1);
      cfg.second_trace <= SIZE_W'(1);
      cfg.inner        <= SIZE_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_OUTER:        cfg.outer        <= size_clamp(wr_data);
        CFG_FIRST_TRACE:  cfg.first_trace  <= size_clamp(wr_data);
        CFG_MIDDLE:       cfg.middle       <= size_clamp(wr_data);
        CFG_SECOND_TRACE: cfg.second_trace <= size_clamp(wr_data);
        CFG_INNER:        cfg.inner        <= size_clamp(wr_data);
        default: ;
      endcase
    end
  end

  // Entry total in two registered multiplies; the drain passes a wait state so
  // a configuration write just before it is already folded in.
  always_ff @(posedge clk) begin
    prod01 <= PROD_W'(cfg.outer) * PROD_W'(cfg.middle);
    total  <= TOT_W'(prod01) * TOT_W'(cfg.inner);
  end

  assign ptr_inc = TOT_W'(ptr) + TOT_W'(1);
  // Last entry: the one that reaches the entry total or the store depth.
  assign is_last = (ptr_inc >= total) || (ptr_inc >= TOT_W'(RESULT_DEPTH));
  assign ptr_next = is_last ? '0 : ptr_inc[ADDR_W-1:0];

  // Hold requests while the sweep runs or an earlier request is in flight.
  assign req.ready  = (state == ST_IDLE) && !clr_busy;
  assign req_accept = req.valid && req.ready;
  assign slot_free  = !rsp_valid || rsp.ready;

  always_comb begin
    state_next       = state;
    advance          = 1'b0;
    rsp_load         = 1'b0;
    acc_ctl.rd_en    = 1'b0;
    acc_ctl.rd_addr  = idx;
    acc_ctl.wr_en    = 1'b0;
    acc_ctl.wr_addr  = idx;
    acc_ctl.wr_zero  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_accept) begin
          if (req.command == CMD_DRAIN) begin
            // Read the entry under the drain pointer right away.
            acc_ctl.rd_en   = 1'b1;
            acc_ctl.rd_addr = ptr;
            state_next      = ST_DWAIT;
          end else begin
            state_next = ST_IDX;
          end
        end
      end
      ST_IDX: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        acc_ctl.rd_en = hit;
        state_next    = ST_ADD;
      end
      ST_ADD: begin
        // Write back the saturated sum and advance the stream position.
        acc_ctl.wr_en = hit;
        advance       = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_DWAIT: begin
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        // Clear the entry once the response slot can take its value.
        if (slot_free) begin
          acc_ctl.wr_en   = 1'b1;
          acc_ctl.wr_addr = ptr;
          acc_ctl.wr_zero = 1'b1;
          rsp_load        = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ptr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        ptr       <= ptr_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      elem <= req.element;
    end
    if (rsp_load) begin
      sum_q  <= rd_data;
      last_q <= is_last;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.sum_value  = sum_q;
  assign rsp.last_entry = last_q;

  tpt_index u_index (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .idx     (idx),
    .hit     (hit)
  );

  tpt_acc_store u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (acc_ctl),
    .element  (elem),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

`ifndef SYNTHESIS
  // The store never sees a read and a write from the sequencer together.
  a_rw_exclusive: assert property (@(posedge clk) disable iff (rst)
    acc_ctl.wr_en |-> !acc_ctl.rd_en)
    else $error("accumulator read and write in the same cycle");

  // A drain request moves on to the wait state for its read data.
  a_drain_path: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.command == CMD_DRAIN) |=> (state == ST_DWAIT))
    else $error("drain request did not enter the read wait");

  // A final entry sends the drain pointer back to the first entry.
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && is_last) |=> (ptr == '0))
    else $error("drain pointer did not wrap after the final entry");

  // The drain pointer stays inside the store.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (32'(ptr) < 32'(RESULT_DEPTH)))
    else $error("drain pointer beyond the accumulator store");
`endif

endmodule

FILE: hw/rtl/tpt_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_index
// Position counters of the element stream and the two-stage entry index.
// ----------------------------------------------------------------------------
module tpt_index import tpt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              advance,
  output logic [ADDR_W-1:0] idx,
  output logic              hit
);

  logic [CNT_W-1:0] outer_cnt;
  logic [CNT_W-1:0] first_cnt;
  logic [CNT_W-1:0] middle_cnt;
  logic [CNT_W-1:0] second_cnt;
  logic [CNT_W-1:0] inner_cnt;

  logic [T1_W-1:0]  t1;
  logic             eq1;
  logic [IDX_W-1:0] idx_full;
  logic             eq2;

  logic w_outer, w_first, w_middle, w_second, w_inner;
  logic c_first, c_middle, c_second, c_inner;

  function automatic logic at_end(input logic [CNT_W-1:0] c, input logic [SIZE_W-1:0] size);
    return ({1'b0, c} + SIZE_W'(1)) >= size;
  endfunction

  assign w_outer  = at_end(outer_cnt, cfg.outer);
  assign w_first  = at_end(first_cnt, cfg.first_trace);
  assign w_middle = at_end(middle_cnt, cfg.middle);
  assign w_second = at_end(second_cnt, cfg.second_trace);
  assign w_inner  = at_end(inner_cnt, cfg.inner);

  assign c_first  = advance && w_outer;
  assign c_middle = c_first && w_first;
  assign c_second = c_middle && w_middle;
  assign c_inner  = c_second && w_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_cnt  <= '0;
      first_cnt  <= '0;
      middle_cnt <= '0;
      second_cnt <= '0;
      inner_cnt  <= '0;
    end else begin
      if (advance) begin
        outer_cnt <= w_outer ? '0 : outer_cnt + CNT_W'(1);
      end
      if (c_first) begin
        first_cnt <= w_first ? '0 : first_cnt + CNT_W'(1);
      end
      if (c_middle) begin
        middle_cnt <= w_middle ? '0 : middle_cnt + CNT_W'(1);
      end
      if (c_second) begin
        second_cnt <= w_second ? '0 : second_cnt + CNT_W'(1);
      end
      if (c_inner) begin
        inner_cnt <= w_inner ? '0 : inner_cnt + CNT_W'(1);
      end
    end
  end

  // Stage one: middle + middle_size * inner. Stage two: outer + outer_size * stage one.
  always_ff @(posedge clk) begin
    t1       <= T1_W'(middle_cnt) + T1_W'(cfg.middle) * T1_W'(inner_cnt);
    eq1      <= (first_cnt == second_cnt);
    idx_full <= IDX_W'(outer_cnt) + IDX_W'(cfg.outer) * IDX_W'(t1);
    eq2      <= eq1;
  end

  assign idx = idx_full[ADDR_W-1:0];
  assign hit = eq2 && (idx_full < IDX_W'(RESULT_DEPTH));

endmodule

FILE: hw/rtl/tpt_acc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_acc_store
// Accumulator memory with saturating update, read-and-clear and reset sweep.
// ----------------------------------------------------------------------------
module tpt_acc_store import tpt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  acc_ctl_t                 ctl,
  input  logic signed [ELEM_W-1:0] element,
  output logic signed [SUM_W-1:0]  rd_data,
  output logic                     clr_busy
);

  logic [SUM_W-1:0]  mem [RESULT_DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [SUM_W-1:0]  wr_data;

  // Sweep zeros through every entry after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(RESULT_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clr_busy) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = ctl.wr_en;
      wr_addr = ctl.wr_addr;
      wr_data = ctl.wr_zero ? '0 : sat_add(rd_data, element);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the partial trace accumulator. Streams tensors and
// drain requests through the request channel under random bursts and
// response stalls. A shadow of the counters, sizes and accumulator store
// predicts every drained entry, which is then compared field by field.
// ----------------------------------------------------------------------------
module testbench;
  import tpt_pkg::*;

  // Run limits and phase shaping.
  localparam int     CYCLE_LIMIT        = 5_000_000;
  localparam int     RANDOM_ITEM_TARGET = 800;
  localparam int     SETTLE_CYCLES      = 8;
  localparam int     LONG_HOLD_CYCLES   = 400;
  localparam int     WELL_FORMED_LIMIT  = 256;
  localparam longint SUM_TOP            = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_BOTTOM         = -SUM_TOP - 1;
  localparam logic signed [ELEM_W-1:0] ELEM_TOP    = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] ELEM_BOTTOM = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef struct packed {
    logic                     command;
    logic signed [ELEM_W-1:0] element;
  } trace_request_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_value;
    logic                    last_entry;
  } trace_entry_t;

  // Response side acceptance patterns.
  typedef enum logic [1:0] {SINK_OPEN, SINK_HALF, SINK_SPARSE} sink_mode_e;

  // Index counters in register order: outer, first trace, middle, second
  // trace, inner.
  typedef logic [4:0][CNT_W-1:0] position_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [SIZE_W-1:0]    wr_data;

  tpt_req_if req_ch ();
  tpt_rsp_if rsp_ch ();

  tensor_partial_trace_accumulator uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // Shadow of the block: effective sizes, stream position, partial sums and
  // the next entry to drain.
  logic [4:0][SIZE_W-1:0]  shape_size;
  position_t               position;
  logic signed [SUM_W-1:0] trace_sum [RESULT_DEPTH];
  logic [ADDR_W-1:0]       drain_slot;

  trace_request_t request_backlog [$];
  trace_entry_t   awaited_entries [$];
  trace_request_t next_request;
  trace_entry_t   expected_entry;

  int         issued_count   = 0;
  int         accepted_count = 0;
  int         push_count     = 0;
  int         drain_count    = 0;
  int         checked_count  = 0;
  int         mismatch_count = 0;
  int         setting_count  = 0;
  int         random_items   = 0;
  int         cycle_count    = 0;
  int         burst_left;
  int         gap_left;
  int         mode_left;
  int         hold_left;
  sink_mode_e sink_mode;
  logic       long_hold_arm;
  logic       long_hold_done;

  // --------------------------------------------------------------------------
  // Shadow model
  // --------------------------------------------------------------------------

  // Advance the stream position by one element; a counter at or past its last
  // value wraps to zero and carries into the next one.
  function automatic position_t next_position(input position_t p);
    position_t q;
    logic      carry;
    q     = p;
    carry = 1'b1;
    for (int a = 0; a < 5; a++) begin
      if (carry) begin
        if (int'(q[a]) + 1 >= int'(shape_size[a])) begin
          q[a] = '0;
        end else begin
          q[a]  = q[a] + 1'b1;
          carry = 1'b0;
        end
      end
    end
    return q;
  endfunction

  // Add a pushed element into its (i,k,m) sum when the traced counters
  // agree and the entry fits in the store; pin at the Q32.16 limits.
  function automatic void accumulate_element(input logic signed [ELEM_W-1:0] e);
    longint flat;
    longint sum;
    flat = longint'(position[CFG_OUTER]) + longint'(shape_size[CFG_OUTER]) *
           (longint'(position[CFG_MIDDLE]) +
            longint'(shape_size[CFG_MIDDLE]) * longint'(position[CFG_INNER]));
    if (position[CFG_FIRST_TRACE] == position[CFG_SECOND_TRACE] && flat < RESULT_DEPTH) begin
      sum = longint'(trace_sum[flat[ADDR_W-1:0]]) + longint'(e);
      if (sum > SUM_TOP) begin
        sum = SUM_TOP;
      end else if (sum < SUM_BOTTOM) begin
        sum = SUM_BOTTOM;
      end
      trace_sum[flat[ADDR_W-1:0]] = sum[SUM_W-1:0];
    end
    position = next_position(position);
  endfunction

  // Read and clear the next sum; a pointer at or past the final entry
  // reports last and wraps.
  function automatic trace_entry_t drain_next_entry();
    longint       total;
    trace_entry_t entry;
    total = longint'(shape_size[CFG_OUTER]) * longint'(shape_size[CFG_MIDDLE]) *
            longint'(shape_size[CFG_INNER]);
    if (total > RESULT_DEPTH) begin
      total = RESULT_DEPTH;
    end
    entry.sum_value       = trace_sum[drain_slot];
    entry.last_entry      = (longint'(drain_slot) + 1 >= total);
    trace_sum[drain_slot] = '0;
    drain_slot            = entry.last_entry ? '0 : drain_slot + 1'b1;
    return entry;
  endfunction

  // Count the pushes that bring the stream back to its first element.
  function automatic int pushes_to_origin();
    position_t probe;
    int        steps;
    probe = position;
    steps = 0;
    while (probe != '0 && steps < 4096) begin
      probe = next_position(probe);
      steps++;
    end
    return steps;
  endfunction

  // Mostly full-range values, with the extremes and small values of both
  // signs mixed in.
  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return ELEM_TOP;
      1:       return ELEM_BOTTOM;
      2, 3:    return $urandom_range(0, 255) - 128;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Write one size register and mirror the clamped value into the shadow.
  task automatic write_size(input logic [CFG_IDX_W-1:0] index, input logic [SIZE_W-1:0] raw);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= index;
    wr_data  <= raw;
    // zero reads as one, anything past the largest size as the largest size
    if (raw == '0) begin
      shape_size[index] = SIZE_W'(1);
    end else if (raw > SIZE_W'(MAX_SIZE)) begin
      shape_size[index] = SIZE_W'(MAX_SIZE);
    end else begin
      shape_size[index] = raw;
    end
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic write_shape(input logic [SIZE_W-1:0] outer_raw, first_raw, middle_raw,
                             second_raw, inner_raw);
    write_size(CFG_OUTER, outer_raw);
    write_size(CFG_FIRST_TRACE, first_raw);
    write_size(CFG_MIDDLE, middle_raw);
    write_size(CFG_SECOND_TRACE, second_raw);
    write_size(CFG_INNER, inner_raw);
    setting_count++;
  endtask

  task automatic queue_request(input logic command, input logic signed [ELEM_W-1:0] element);
    request_backlog.push_back(trace_request_t'{command, element});
    issued_count++;
  endtask

  // Hold until every queued request is taken and every drained entry is
  // back, then let an in-flight push finish.
  task automatic settle();
    while (accepted_count != issued_count || awaited_entries.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps. Some
  // bursts come with no gap at all so the input runs back to back.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid   <= 1'b0;
      req_ch.command <= CMD_PUSH;
      req_ch.element <= '0;
      burst_left     <= 0;
      gap_left       <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (gap_left != 0) begin
        req_ch.valid <= 1'b0;
        gap_left     <= gap_left - 1;
      end else if (request_backlog.size() != 0) begin
        next_request   = request_backlog.pop_front();
        req_ch.valid   <= 1'b1;
        req_ch.command <= next_request.command;
        req_ch.element <= next_request.element;
        if (burst_left < 2) begin
          burst_left <= $urandom_range(1, 32);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response acceptor: switches among open, half and sparse acceptance.
  // Once armed, the first response it sees starts one long hold-off so the
  // single response slot fills and the next drain request holds up the request side.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready   <= 1'b0;
      sink_mode      <= SINK_OPEN;
      mode_left      <= 0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold_arm && !long_hold_done && rsp_ch.valid) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD_CYCLES;
      rsp_ch.ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_mode <= sink_mode_e'($urandom_range(0, 2));
        mode_left <= $urandom_range(8, 64);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (sink_mode)
        SINK_OPEN: begin
          rsp_ch.ready <= 1'b1;
        end
        SINK_HALF: begin
          rsp_ch.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each returned entry against the oldest prediction, then
  // advance the shadow for a request taken at this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_entries.size() == 0) begin
          $error("sum_value: entry returned with no drain outstanding, actual %0d",
                 rsp_ch.sum_value);
          mismatch_count++;
        end else begin
          expected_entry = awaited_entries.pop_front();
          checked_count++;
          if (rsp_ch.sum_value !== expected_entry.sum_value) begin
            $error("sum_value mismatch: expected %0d, actual %0d",
                   expected_entry.sum_value, rsp_ch.sum_value);
            mismatch_count++;
          end
          if (rsp_ch.last_entry !== expected_entry.last_entry) begin
            $error("last_entry mismatch: expected %0d, actual %0d",
                   expected_entry.last_entry, rsp_ch.last_entry);
            mismatch_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        accepted_count++;
        if (req_ch.command == CMD_PUSH) begin
          accumulate_element(req_ch.element);
          push_count++;
        end else begin
          awaited_entries.push_back(drain_next_entry());
          drain_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end a hung run.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [4:0][SIZE_W-1:0] raw;
    longint                 elements;
    longint                 entries;
    int                     style;
    int                     count;
    int                     a;
    int                     n;

    // Shadow state after reset: sizes of one, empty store, origin.
    for (a = 0; a < RESULT_DEPTH; a++) begin
      trace_sum[a] = '0;
    end
    for (a = 0; a < 5; a++) begin
      shape_size[a] = SIZE_W'(1);
    end
    position   = '0;
    drain_slot = '0;

    rst            <= 1'b1;
    wr_en          <= 1'b0;
    wr_index       <= CFG_OUTER;
    wr_data        <= '0;
    long_hold_arm  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes: every push lands on entry zero and the counters wrap on
    // each push. Sum the element extremes, then drain twice so the second
    // read shows the cleared entry.
    queue_request(CMD_PUSH, ELEM_TOP);
    queue_request(CMD_PUSH, ELEM_BOTTOM);
    queue_request(CMD_PUSH, -1);
    queue_request(CMD_PUSH, 0);
    queue_request(CMD_PUSH, 1);
    queue_request(CMD_DRAIN, pick_element());
    queue_request(CMD_DRAIN, pick_element());
    settle();

    // Zero sizes read as one, an oversized trace axis as the largest size.
    // Drain part way, then shrink the entry count under the pointer so the
    // next drain lands past the final entry and wraps.
    write_shape(0, (1 << SIZE_W) - 1, 3, 1, 0);
    repeat (3) queue_request(CMD_PUSH, pick_element());
    repeat (2) queue_request(CMD_DRAIN, pick_element());
    settle();
    write_size(CFG_MIDDLE, 1);
    repeat (2) queue_request(CMD_DRAIN, pick_element());
    settle();

    // Two by two trace: only the diagonal pushes count.
    write_shape(1, 2, 1, 2, 1);
    repeat (pushes_to_origin()) queue_request(CMD_PUSH, pick_element());
    queue_request(CMD_PUSH, 100);
    queue_request(CMD_PUSH, 7);
    queue_request(CMD_PUSH, -3);
    queue_request(CMD_PUSH, ELEM_TOP);
    queue_request(CMD_DRAIN, pick_element());
    settle();

    // Entries past the store: walk the middle counter up, then widen the
    // outer size so the next pushes index past the store and drop.
    write_shape(1, 1, MAX_SIZE, 1, 1);
    n = pushes_to_origin();
    repeat (n + 5) queue_request(CMD_PUSH, pick_element());
    settle();
    write_size(CFG_OUTER, MAX_SIZE);
    write_size(CFG_MIDDLE, 1);
    repeat (3) queue_request(CMD_PUSH, pick_element());
    repeat (8) queue_request(CMD_DRAIN, pick_element());
    settle();

    // Random shapes. Small ones mostly get whole tensors followed by a drain of
    // all entries, part of them or up to three past the final entry; the rest get
    // short random mixes that leave the stream and pointer somewhere in the middle.
    long_hold_arm <= 1'b1;
    while (random_items < RANDOM_ITEM_TARGET) begin
      for (a = 0; a < 5; a++) begin
        case ($urandom_range(0, 19))
          0, 1:    raw[a] = '0;
          2:       raw[a] = $urandom_range(MAX_SIZE + 1, (1 << SIZE_W) - 1);
          3:       raw[a] = SIZE_W'(MAX_SIZE);
          4, 5:    raw[a] = $urandom_range(5, 12);
          default: raw[a] = $urandom_range(1, 4);
        endcase
      end
      write_shape(raw[0], raw[1], raw[2], raw[3], raw[4]);
      elements = 1;
      for (a = 0; a < 5; a++) begin
        elements = elements * longint'(shape_size[a]);
      end
      entries = longint'(shape_size[CFG_OUTER]) * longint'(shape_size[CFG_MIDDLE]) *
                longint'(shape_size[CFG_INNER]);
      if (entries > RESULT_DEPTH) begin
        entries = RESULT_DEPTH;
      end
      style = $urandom_range(0, 9);
      if (elements <= WELL_FORMED_LIMIT && style < 7) begin
        // Realign to the first element, stream the tensor once or twice.
        count = pushes_to_origin() + int'(elements) * $urandom_range(1, 2);
        repeat (count) queue_request(CMD_PUSH, pick_element());
        n = int'(entries);
        if (style == 5) begin
          // stop part way so the next shape starts with a live pointer
          n = $urandom_range(1, n);
        end else if (style == 6) begin
          // run past the final entry and wrap
          n = n + $urandom_range(1, 3);
        end
        repeat (n) queue_request(CMD_DRAIN, pick_element());
        random_items += count + n;
      end else begin
        n = $urandom_range(8, 40);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            queue_request(CMD_DRAIN, pick_element());
          end else begin
            queue_request(CMD_PUSH, pick_element());
          end
        end
        random_items += n;
      end
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d pushes and %0d drains over %0d shape settings,", push_count,
             drain_count, setting_count);
    $display("entries past the store included; %0d entries checked, %0d mismatches.",
             checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
